// ----- sv/assert_macros.svh -----
// Assertion helpers used by the search sequencer (zics_search).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/zics_pkg.sv -----
package zics_pkg;

    // Default sizing
    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_FRACTION_BITS = 32;

    // Fixed field widths
    localparam int SIZE_W   = 11;
    localparam int INDEX_W  = 11;
    localparam int SAMPLE_W = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Function codes carried in the input tuser
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Control from the top level to the search sequencer
    typedef struct packed {
        logic start;     // sample transaction accepted this cycle
        logic out_free;  // output register can take a result this cycle
    } t_seq_ctl;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] value;
        logic                rejected;
    } t_result;

endpackage

// ----- sv/zics_cdf_ram.sv -----
module zics_cdf_ram
    import zics_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int WIDTH = DEF_FRACTION_BITS + 1
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry per load transaction
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered reads on two ports
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// ----- sv/zics_search.sv -----
`include "assert_macros.svh"

module zics_search
    import zics_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_seq_ctl                           i_ctl,
    input  logic [FRACTION_BITS-1:0]           i_uniform,
    input  logic [$clog2(TABLE_DEPTH+2)-1:0]   i_size,
    output logic                               o_ready,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_rd_addr_a,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_rd_addr_b,
    input  logic [FRACTION_BITS:0]             i_rd_data_a,
    input  logic [FRACTION_BITS:0]             i_rd_data_b,
    output t_result                            o_result
);

    localparam int IW = $clog2(TABLE_DEPTH + 2);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = FRACTION_BITS + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [IW-1:0]            r_lo, n_lo;
    logic [IW-1:0]            r_hi, n_hi;
    logic [IW-1:0]            r_mid, n_mid;
    logic [IW-1:0]            r_n, n_n;
    logic [FRACTION_BITS-1:0] r_u, n_u;
    logic [SAMPLE_W-1:0]      r_res_value, n_res_value;
    logic                     r_res_rej, n_res_rej;

    logic [IW:0]   w_sum;
    logic [IW-1:0] w_mid;
    logic [EW-1:0] w_here;
    logic [EW-1:0] w_prev;
    logic [EW-1:0] w_u_ext;
    logic          w_here_ge;
    logic          w_prev_lt;
    logic          w_hit;

    // Midpoint of the current interval
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[IW:1];

    // Probe rank mid and rank mid-1 (entry of rank r sits at address r-1)
    assign o_rd_addr_a = AW'(w_mid - IW'(1));
    assign o_rd_addr_b = AW'(w_mid - IW'(2));

    // Shared compare against the fraction; rank 0 reads as zero
    assign w_here    = i_rd_data_a;
    assign w_prev    = (r_mid == IW'(1)) ? '0 : i_rd_data_b;
    assign w_u_ext   = {1'b0, r_u};
    assign w_here_ge = (w_here >= w_u_ext);
    assign w_prev_lt = (w_prev < w_u_ext);
    assign w_hit     = w_here_ge && w_prev_lt;

    assign o_ready           = (r_state == ST_IDLE);
    assign o_result.done     = (r_state == ST_HOLD) && i_ctl.out_free;
    assign o_result.value    = r_res_value;
    assign o_result.rejected = r_res_rej;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_n         = r_n;
        n_u         = r_u;
        n_res_value = r_res_value;
        n_res_rej   = r_res_rej;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_u  = i_uniform;
                    n_lo = IW'(1);
                    n_hi = i_size;
                    n_n  = i_size;
                    if (i_uniform == '0) begin
                        n_res_value = '0;
                        n_res_rej   = 1'b1;
                        n_state     = ST_HOLD;
                    end else begin
                        n_state = ST_ADDR;
                    end
                end
            end
            ST_ADDR: begin
                if (r_lo <= r_hi) begin
                    n_mid   = w_mid;
                    n_state = ST_CMP;
                end else begin
                    // no hit: saturate to the table size
                    n_res_value = SAMPLE_W'(r_n);
                    n_res_rej   = 1'b0;
                    n_state     = ST_HOLD;
                end
            end
            ST_CMP: begin
                if (w_hit) begin
                    n_res_value = SAMPLE_W'(r_mid);
                    n_res_rej   = 1'b0;
                    n_state     = ST_HOLD;
                end else if (w_here_ge) begin
                    n_hi    = r_mid - IW'(1);
                    n_state = ST_ADDR;
                end else begin
                    n_lo    = r_mid + IW'(1);
                    n_state = ST_ADDR;
                end
            end
            ST_HOLD: begin
                if (i_ctl.out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_n         <= n_n;
        r_u         <= n_u;
        r_res_value <= n_res_value;
        r_res_rej   <= n_res_rej;
    end

    `ASSERT_ALWAYS(a_mid_in_range, i_clk, i_rst_n,
        (r_state != ST_CMP) || ((r_mid >= r_lo) && (r_mid <= r_hi)),
        "probe rank outside search interval")
    `ASSERT_ALWAYS(a_hi_bounded, i_clk, i_rst_n,
        ((r_state != ST_ADDR) && (r_state != ST_CMP)) || (r_hi <= r_n),
        "upper bound above table size")
    `ASSERT_NEXT(a_hold_stable, i_clk, i_rst_n,
        (r_state == ST_HOLD) && !i_ctl.out_free,
        (r_state == ST_HOLD) && $stable(r_res_value) && $stable(r_res_rej),
        "held result changed while output stalled")

endmodule

// ----- sv/zipf_inverse_cdf_sampler_top.sv -----
// Zipf rank sampler by inverse cumulative distribution.
// Input stream (s_axis): tuser is the function, 0 loads one cumulative table
// entry, 1 draws one sample. A load writes in the cycle it is accepted and
// gives no result. A sample runs a binary search over ranks 1..table_size.
// Output stream (m_axis): one transaction per sample, the rank in tdata and
// the rejected flag in tuser (set for a zero fraction, rank then 0).
// Config channel (i_cfg_*): writes table_size; always ready; write it only
// while no sample is in flight.
// Each probe takes two states on the shared two-port table read and compare
// (address state, compare state); a hit or a closed interval goes to the hold
// state, and a rejected sample goes there straight from idle.
// The input is not ready while a sample is being searched or its result is
// held for the output register, so a new sample enters only once the last
// result has passed to the output register; loads every cycle while idle.
// The output register lets the next transaction enter while a result waits.
// Reset sets table_size to 1024 and empties the pipeline; table contents are
// undefined until loaded. A stalled receiver holds the result in place.
module zipf_inverse_cdf_sampler_top
    import zics_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int IN_DATA_W     = ((INDEX_W + 2 * FRACTION_BITS + 1 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index, entry_value, uniform (low bits first), zero padded
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sample_value, zero padded
    output logic [15:0]           m_axis_tdata,
    // rejected
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SIZE_W-1:0]     i_cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH + 2);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = FRACTION_BITS + 1;

    logic [SIZE_W-1:0] r_table_size;
    logic              r_out_valid;
    logic [SAMPLE_W-1:0] r_out_value;
    logic              r_out_rej;

    logic                     w_accept;
    logic                     w_load;
    logic [INDEX_W-1:0]       w_index;
    logic [EW-1:0]            w_value;
    logic [FRACTION_BITS-1:0] w_uniform;
    logic                     w_index_ok;
    logic [IW-1:0]            w_size;
    logic                     w_ready;
    t_seq_ctl                 w_ctl;
    t_result                  w_result;
    logic [AW-1:0]            w_rd_addr_a;
    logic [AW-1:0]            w_rd_addr_b;
    logic [EW-1:0]            w_rd_data_a;
    logic [EW-1:0]            w_rd_data_b;

    // Unpack the input transaction
    assign w_index   = s_axis_tdata[INDEX_W-1:0];
    assign w_value   = s_axis_tdata[INDEX_W +: EW];
    assign w_uniform = s_axis_tdata[INDEX_W + EW +: FRACTION_BITS];

    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_index_ok    = (w_index != '0) && (int'(w_index) <= TABLE_DEPTH);
    assign w_load        = w_accept && (s_axis_tuser == FUNC_LOAD) && w_index_ok;

    // Clamp the table size into 1..TABLE_DEPTH
    always_comb begin
        if (r_table_size == '0) begin
            w_size = IW'(1);
        end else if (int'(r_table_size) > TABLE_DEPTH) begin
            w_size = IW'(TABLE_DEPTH);
        end else begin
            w_size = IW'(r_table_size);
        end
    end

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    assign w_ctl.start    = w_accept && (s_axis_tuser == FUNC_SAMPLE);
    assign w_ctl.out_free = !r_out_valid || m_axis_tready;

    zics_cdf_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_load),
        .i_wr_addr   (AW'(w_index - INDEX_W'(1))),
        .i_wr_data   (w_value),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    zics_search #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_uniform   (w_uniform),
        .i_size      (w_size),
        .o_ready     (w_ready),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .i_rd_data_a (w_rd_data_a),
        .i_rd_data_b (w_rd_data_b),
        .o_result    (w_result)
    );

    // Output register: load a result, drop it once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.done) begin
            r_out_value <= w_result.value;
            r_out_rej   <= w_result.rejected;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_value);
    assign m_axis_tuser  = r_out_rej;

endmodule
